### hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared constants, register indexes and 32-bit helper functions for the
// barometric pressure compensation pipeline
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned SB_W = 64;

  typedef logic [SB_W-1:0] sb_t;

  typedef enum logic [2:0] {
    REG_AC1_AC2_AC3 = 3'd0,
    REG_AC4_AC5_AC6 = 3'd1,
    REG_B1_B2       = 3'd2,
    REG_MC_MD       = 3'd3,
    REG_OSS         = 3'd4
  } cfg_reg_t;

  localparam logic [31:0] C_B6_OFFSET  = 32'd4000;
  localparam logic [31:0] C_B7_SCALE   = 32'd50000;
  localparam logic [31:0] C_B4_OFFSET  = 32'd32768;
  localparam logic [31:0] C_P_SQ_COEF  = 32'd3038;
  localparam logic [31:0] C_P_LIN_COEF = 32'hFFFF_E343;
  localparam logic [31:0] C_P_OFFSET   = 32'd3791;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    logic signed [31:0] s;
    s = $signed(x) >>> n;
    return s;
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] full;
    full = a * b;
    return full[31:0];
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

### hdl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// pipelined 32-bit unsigned restoring divider, one quotient bit per stage,
// with a sideband word that travels alongside each item
// ----------------------------------------------------------------------------
module bpc_div
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_num,
  input  logic [31:0] in_den,
  input  sb_t         in_sb,
  output logic        out_valid,
  output logic [31:0] out_quot,
  output sb_t         out_sb
);

  logic        v_r  [0:32];
  logic [31:0] r_r  [0:32];
  logic [31:0] nq_r [0:32];
  logic [31:0] d_r  [0:32];
  sb_t         sb_r [0:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]  <= '0;
      nq_r[0] <= in_num;
      d_r[0]  <= in_den;
      sb_r[0] <= in_sb;
    end
  end

  for (genvar i = 1; i <= 32; i++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;
    logic [31:0] r_nxt;

    always_comb begin
      trial = {r_r[i-1], nq_r[i-1][31]};
      diff  = trial - {1'b0, d_r[i-1]};
      qbit  = !diff[32];
      r_nxt = qbit ? diff[31:0] : trial[31:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]  <= r_nxt;
        nq_r[i] <= {nq_r[i-1][30:0], qbit};
        d_r[i]  <= d_r[i-1];
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign out_valid = v_r[32];
  assign out_quot  = nq_r[32];
  assign out_sb    = sb_r[32];

endmodule

### hdl/barometric_pressure_compensation_top.sv
// throughput: one item per cycle while out_ready allows; set by the two 33-stage divider pipelines
// a stall on the result side holds every stage in place
// reset: synchronous active-low rst_n clears valid bits and calibration to 0
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// integer temperature and pressure compensation pipeline with two
// bit-per-stage dividers
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_temperature,
  input  logic [23:0]        in_raw_pressure_bytes,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature_tenths,
  output logic [23:0]        out_pressure_pa,
  output logic               out_divide_fault
);

  logic [47:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r, cal_d_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      cal_d_r <= '0;
      oss_r   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_AC1_AC2_AC3: cal_a_r <= cfg_data;
        REG_AC4_AC5_AC6: cal_b_r <= cfg_data;
        REG_B1_B2:       cal_c_r <= cfg_data[31:0];
        REG_MC_MD:       cal_d_r <= cfg_data[31:0];
        REG_OSS:         oss_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal_a_r[47:32]);
  assign ac2 = sx16(cal_a_r[31:16]);
  assign ac3 = sx16(cal_a_r[15:0]);
  assign ac4 = {16'd0, cal_b_r[47:32]};
  assign ac5 = {16'd0, cal_b_r[31:16]};
  assign ac6 = {16'd0, cal_b_r[15:0]};
  assign b1  = sx16(cal_c_r[31:16]);
  assign b2  = sx16(cal_c_r[15:0]);
  assign mc  = sx16(cal_d_r[31:16]);
  assign md  = sx16(cal_d_r[15:0]);

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage a
  logic        a_v_r;
  logic [31:0] a_prod_r, a_prod_nxt;
  logic [23:0] a_up_r, a_up_nxt;

  always_comb begin
    a_prod_nxt = mul32({16'd0, in_raw_temperature} - ac6, ac5);
    a_up_nxt   = in_raw_pressure_bytes >> (4'd8 - {2'b00, oss_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= a_prod_nxt;
      a_up_r   <= a_up_nxt;
    end
  end

  // temperature divider setup
  logic [31:0] t_x1, t_den, t_num, t_num_mag, t_den_mag;
  logic        t_fault, t_qneg;
  sb_t         d1_sb_in, d1_sb_out;
  logic        d1_v;
  logic [31:0] d1_q;

  always_comb begin
    t_x1      = asr32(a_prod_r, 5'd15);
    t_den     = t_x1 + md;
    t_num     = {mc[20:0], 11'd0};
    t_fault   = (t_den == 32'd0);
    t_num_mag = t_num[31] ? (32'd0 - t_num) : t_num;
    t_den_mag = t_den[31] ? (32'd0 - t_den) : t_den;
    t_qneg    = t_num[31] ^ t_den[31];
    d1_sb_in  = {6'd0, t_qneg, t_fault, a_up_r, t_x1};
  end

  bpc_div u_div_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_v_r),
    .in_num    (t_num_mag),
    .in_den    (t_den_mag),
    .in_sb     (d1_sb_in),
    .out_valid (d1_v),
    .out_quot  (d1_q),
    .out_sb    (d1_sb_out)
  );

  // stage c
  logic        c_v_r, c_tf_r;
  logic [31:0] c_b6_r, c_b6_nxt;
  logic [15:0] c_t_r, c_t_nxt;
  logic [23:0] c_up_r;
  logic [31:0] c_x2, c_b5, c_t32;

  always_comb begin
    c_x2  = d1_sb_out[57] ? (32'd0 - d1_q) : d1_q;
    c_b5  = d1_sb_out[31:0] + c_x2;
    c_t32 = asr32(c_b5 + 32'd8, 5'd4);
    if ($signed(c_t32) > 32'sd32767) begin
      c_t_nxt = 16'h7FFF;
    end else if ($signed(c_t32) < -32'sd32768) begin
      c_t_nxt = 16'h8000;
    end else begin
      c_t_nxt = c_t32[15:0];
    end
    c_b6_nxt = c_b5 - C_B6_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_b6_r <= c_b6_nxt;
      c_t_r  <= c_t_nxt;
      c_up_r <= d1_sb_out[55:32];
      c_tf_r <= d1_sb_out[56];
    end
  end

  // stage d
  logic        d_v_r, d_tf_r;
  logic [31:0] d_sq_r, d_ac2_r, d_ac3_r;
  logic [15:0] d_t_r;
  logic [23:0] d_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sq_r  <= mul32(c_b6_r, c_b6_r);
      d_ac2_r <= mul32(ac2, c_b6_r);
      d_ac3_r <= mul32(ac3, c_b6_r);
      d_t_r   <= c_t_r;
      d_up_r  <= c_up_r;
      d_tf_r  <= c_tf_r;
    end
  end

  // stage e
  logic        e_v_r, e_tf_r;
  logic [31:0] e_b2s_r, e_b1s_r, e_x2a_r, e_x1b_r, e_s;
  logic [15:0] e_t_r;
  logic [23:0] e_up_r;

  assign e_s = asr32(d_sq_r, 5'd12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_b2s_r <= mul32(b2, e_s);
      e_b1s_r <= mul32(b1, e_s);
      e_x2a_r <= asr32(d_ac2_r, 5'd11);
      e_x1b_r <= asr32(d_ac3_r, 5'd13);
      e_t_r   <= d_t_r;
      e_up_r  <= d_up_r;
      e_tf_r  <= d_tf_r;
    end
  end

  // stage f
  logic        f_v_r, f_tf_r;
  logic [31:0] f_v3_r, f_v3_nxt, f_x3b_r, f_x3b_nxt, f_x3;
  logic [15:0] f_t_r;
  logic [23:0] f_up_r;

  always_comb begin
    f_x3      = asr32(e_b2s_r, 5'd11) + e_x2a_r;
    f_v3_nxt  = (({ac1[29:0], 2'b00} + f_x3) << oss_r) + 32'd2;
    f_x3b_nxt = asr32(e_x1b_r + asr32(e_b1s_r, 5'd16) + 32'd2, 5'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_v3_r  <= f_v3_nxt;
      f_x3b_r <= f_x3b_nxt;
      f_t_r   <= e_t_r;
      f_up_r  <= e_up_r;
      f_tf_r  <= e_tf_r;
    end
  end

  // stage g
  logic        g_v_r, g_tf_r;
  logic [31:0] g_b7pre_r, g_b4p_r, g_b3;
  logic [15:0] g_t_r;

  // truncating divide by four
  assign g_b3 = f_v3_r[31] ? asr32(f_v3_r + 32'd3, 5'd2) : asr32(f_v3_r, 5'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_b7pre_r <= {8'd0, f_up_r} - g_b3;
      g_b4p_r   <= mul32(ac4, f_x3b_r + C_B4_OFFSET);
      g_t_r     <= f_t_r;
      g_tf_r    <= f_tf_r;
    end
  end

  // stage h
  logic        h_v_r, h_tf_r;
  logic [31:0] h_b4_r, h_b7_r;
  logic [15:0] h_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_b4_r <= g_b4p_r >> 15;
      h_b7_r <= mul32(g_b7pre_r, C_B7_SCALE >> oss_r);
      h_t_r  <= g_t_r;
      h_tf_r <= g_tf_r;
    end
  end

  // pressure divider setup
  logic        p_hi, p_fault;
  logic [31:0] p_num;
  sb_t         d2_sb_in, d2_sb_out;
  logic        d2_v;
  logic [31:0] d2_q;

  always_comb begin
    p_hi     = h_b7_r[31];
    p_num    = p_hi ? h_b7_r : {h_b7_r[30:0], 1'b0};
    p_fault  = (h_b4_r == 32'd0);
    d2_sb_in = {45'd0, p_hi, p_fault, h_tf_r, h_t_r};
  end

  bpc_div u_div_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_v_r),
    .in_num    (p_num),
    .in_den    (h_b4_r),
    .in_sb     (d2_sb_in),
    .out_valid (d2_v),
    .out_quot  (d2_q),
    .out_sb    (d2_sb_out)
  );

  // stage i
  logic        i_v_r, i_tf_r, i_pf_r;
  logic [31:0] i_p_r, i_sq_r, i_m2_r, i_p, i_x1;
  logic [15:0] i_t_r;

  always_comb begin
    i_p  = d2_sb_out[18] ? {d2_q[30:0], 1'b0} : d2_q;
    i_x1 = asr32(i_p, 5'd8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r <= 1'b0;
    end else if (en) begin
      i_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_p_r  <= i_p;
      i_sq_r <= mul32(i_x1, i_x1);
      i_m2_r <= mul32(C_P_LIN_COEF, i_p);
      i_t_r  <= d2_sb_out[15:0];
      i_tf_r <= d2_sb_out[16];
      i_pf_r <= d2_sb_out[17];
    end
  end

  // stage j
  logic        j_v_r, j_tf_r, j_pf_r;
  logic [31:0] j_p_r, j_x1_r, j_x2_r;
  logic [15:0] j_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_v_r <= 1'b0;
    end else if (en) begin
      j_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_p_r  <= i_p_r;
      j_x1_r <= asr32(mul32(i_sq_r, C_P_SQ_COEF), 5'd16);
      j_x2_r <= asr32(i_m2_r, 5'd16);
      j_t_r  <= i_t_r;
      j_tf_r <= i_tf_r;
      j_pf_r <= i_pf_r;
    end
  end

  // output stage
  logic [31:0] k_p;
  logic [23:0] k_pa_nxt, pa_r;
  logic [15:0] k_t_nxt, t_r;
  logic        k_f_nxt, f_r;

  always_comb begin
    k_p = j_p_r + asr32(j_x1_r + j_x2_r + C_P_OFFSET, 5'd4);
    if (k_p[31]) begin
      k_pa_nxt = 24'd0;
    end else if (k_p[30:24] != 7'd0) begin
      k_pa_nxt = 24'hFF_FFFF;
    end else begin
      k_pa_nxt = k_p[23:0];
    end
    k_t_nxt = j_t_r;
    k_f_nxt = 1'b0;
    if (j_tf_r) begin
      k_t_nxt  = 16'h7FFF;
      k_pa_nxt = 24'hFF_FFFF;
      k_f_nxt  = 1'b1;
    end else if (j_pf_r) begin
      k_pa_nxt = 24'hFF_FFFF;
      k_f_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= k_t_nxt;
      pa_r <= k_pa_nxt;
      f_r  <= k_f_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = t_r;
  assign out_pressure_pa        = pa_r;
  assign out_divide_fault       = f_r;

endmodule

### hdl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// port-level checks on the compensation pipeline, bound to the top level
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_temperature_tenths,
  input logic [23:0] out_pressure_pa,
  input logic        out_divide_fault
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_pa)
      && $stable(out_temperature_tenths) && $stable(out_divide_fault))
    else $error("stalled result changed");

  a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> out_pressure_pa == 24'hFF_FFFF)
    else $error("fault without saturated pressure");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_temperature_tenths (out_temperature_tenths),
  .out_pressure_pa        (out_pressure_pa),
  .out_divide_fault       (out_divide_fault)
);

### bench/barometric_pressure_compensation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top_tb
// drives raw temperature and pressure items through the compensation pipeline
// under several calibration sets, predicts each result with an in-bench
// integer model and checks every output item in order
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top_tb
  import bpc_pkg::*;
;

  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] raw_p;
  } sample_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [23:0] pres;
    logic        fault;
  } comp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_raw_temperature = '0;
  logic [23:0] in_raw_pressure_bytes = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_temperature_tenths;
  logic [23:0] out_pressure_pa;
  logic out_divide_fault;

  logic [47:0] cal_a123, cal_a456;
  logic [31:0] cal_b12, cal_mcmd;
  logic [1:0] oss;

  sample_t pending_samples[$];
  comp_t expected_comp[$];
  int mismatches = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit hold_go = 1'b0;
  bit hold_off = 1'b0;

  barometric_pressure_compensation_top uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sdv(logic [31:0] a, logic [31:0] b);
    longint q;
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  function automatic comp_t compensate(sample_t s);
    comp_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, b3, b4, b7, p, t;
    ac1 = {{16{cal_a123[47]}}, cal_a123[47:32]};
    ac2 = {{16{cal_a123[31]}}, cal_a123[31:16]};
    ac3 = {{16{cal_a123[15]}}, cal_a123[15:0]};
    ac4 = {16'd0, cal_a456[47:32]};
    ac5 = {16'd0, cal_a456[31:16]};
    ac6 = {16'd0, cal_a456[15:0]};
    b1 = {{16{cal_b12[31]}}, cal_b12[31:16]};
    b2 = {{16{cal_b12[15]}}, cal_b12[15:0]};
    mc = {{16{cal_mcmd[31]}}, cal_mcmd[31:16]};
    md = {{16{cal_mcmd[15]}}, cal_mcmd[15:0]};
    ut = {16'd0, s.ut};
    up = {8'd0, s.raw_p} >> (8 - oss);
    x1 = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.temp = 16'h7FFF;
      r.pres = 24'hFFFFFF;
      r.fault = 1'b1;
      return r;
    end
    x2 = sdv(mc * 32'd2048, den);
    b5 = x1 + x2;
    t = sra(b5 + 32'd8, 4);
    if ($signed(t) > 32767) r.temp = 16'h7FFF;
    else if ($signed(t) < -32768) r.temp = 16'h8000;
    else r.temp = t[15:0];
    b6 = b5 - 32'd4000;
    x1 = sra(b2 * sra(b6 * b6, 12), 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sdv(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sra(b6 * b6, 12), 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    b7 = (up - b3) * (32'd50000 >> oss);
    if (b4 == 0) begin
      r.pres = 24'hFFFFFF;
      r.fault = 1'b1;
      return r;
    end
    if (b7 < 32'h80000000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = sra(p, 8);
    x1 = x1 * x1;
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra((32'd0 - 32'd7357) * p, 16);
    p = p + sra(x1 + x2 + 32'd3791, 4);
    if ($signed(p) < 0) r.pres = 24'd0;
    else if ($signed(p) > 32'sd16777215) r.pres = 24'hFFFFFF;
    else r.pres = p[23:0];
    r.fault = 1'b0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_comp.push_back(compensate({in_raw_temperature, in_raw_pressure_bytes}));
    end
    if (in_valid && !in_ready) begin
    end else if (tx_wait > 0) begin
      in_valid <= 1'b0;
      tx_wait <= tx_wait - 1;
    end else if (pending_samples.size() > 0 && rst_n) begin
      sample_t s;
      s = pending_samples.pop_front();
      in_valid <= 1'b1;
      in_raw_temperature <= s.ut;
      in_raw_pressure_bytes <= s.raw_p;
      tx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      comp_t e;
      if (expected_comp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item t=%0d p=%0d f=%0d",
          out_temperature_tenths, out_pressure_pa, out_divide_fault);
      end else begin
        e = expected_comp.pop_front();
        if (e.temp !== out_temperature_tenths || e.pres !== out_pressure_pa ||
            e.fault !== out_divide_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp t=%0d p=%0d f=%0d act t=%0d p=%0d f=%0d",
              $signed(e.temp), e.pres, e.fault, out_temperature_tenths,
              out_pressure_pa, out_divide_fault);
        end
      end
    end
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready)
        rx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_AC1_AC2_AC3: cal_a123 = val;
      REG_AC4_AC5_AC6: cal_a456 = val;
      REG_B1_B2: cal_b12 = val[31:0];
      REG_MC_MD: cal_mcmd = val[31:0];
      default: oss = val[1:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid || expected_comp.size() > 0)
      @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic queue_sample(logic [15:0] ut, logic [23:0] rp);
    sample_t s;
    s.ut = ut;
    s.raw_p = rp;
    pending_samples.push_back(s);
  endtask

  task automatic load_cal(int kind);
    case (kind)
      0: begin
        write_reg(REG_AC1_AC2_AC3, {16'd408, -16'sd72, -16'sd14383});
        write_reg(REG_AC4_AC5_AC6, {16'd32741, 16'd32757, 16'd23153});
        write_reg(REG_B1_B2, {16'd0, 16'd6190, 16'd4});
        write_reg(REG_MC_MD, {16'd0, -16'sd8711, 16'd2868});
      end
      1: begin
        write_reg(REG_AC1_AC2_AC3, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_AC4_AC5_AC6, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_B1_B2, 48'h0000_FFFF_FFFF);
        write_reg(REG_MC_MD, 48'h0000_FFFF_FFFF);
      end
      2: begin
        write_reg(REG_AC1_AC2_AC3, 48'h8000_7FFF_8000);
        write_reg(REG_AC4_AC5_AC6, 48'h0000_8000_FFFF);
        write_reg(REG_B1_B2, 48'h0000_7FFF_8000);
        write_reg(REG_MC_MD, 48'h0000_8000_0000);
      end
      default: begin
        write_reg(REG_AC1_AC2_AC3, {16'($urandom), $urandom});
        write_reg(REG_AC4_AC5_AC6, {16'($urandom), $urandom});
        write_reg(REG_B1_B2, {16'd0, $urandom});
        write_reg(REG_MC_MD, ($urandom_range(0, 7) == 0) ?
          {16'd0, 16'($urandom), 16'd0} : {16'd0, $urandom});
      end
    endcase
  endtask

  initial begin
    int phase;
    cal_a123 = '0;
    cal_a456 = '0;
    cal_b12 = '0;
    cal_mcmd = '0;
    oss = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // all-zero calibration: temperature divisor is zero
    queue_sample(16'd0, 24'd0);
    queue_sample(16'hFFFF, 24'hFFFFFF);
    wait_drained();
    load_cal(0);
    write_reg(REG_OSS, 48'd0);
    queue_sample(16'd27898, 24'd23843 << 8);
    queue_sample(16'd0, 24'd0);
    queue_sample(16'hFFFF, 24'hFFFFFF);
    queue_sample(16'h8000, 24'h800000);
    queue_sample(16'd23153, 24'h5D2300);
    wait_drained();
    // zero pressure divisor: ac4 zero
    write_reg(REG_AC4_AC5_AC6, {16'd0, 16'd32757, 16'd23153});
    queue_sample(16'd27898, 24'h5D2300);
    queue_sample(16'd1000, 24'hFFFFFF);
    wait_drained();
    load_cal(1);
    write_reg(REG_OSS, 48'd3);
    queue_sample(16'd0, 24'd0);
    queue_sample(16'hFFFF, 24'hFFFFFF);
    queue_sample(16'h1234, 24'h00FFFF);
    wait_drained();
    load_cal(2);
    queue_sample(16'd0, 24'hFFFFFF);
    queue_sample(16'hFFFF, 24'd0);
    queue_sample(16'h7FFF, 24'h7FFFFF);
    wait_drained();
    for (phase = 0; phase < 8; phase++) begin
      load_cal(phase < 2 ? 0 : (phase == 5 ? 1 : 3));
      write_reg(REG_OSS, {46'd0, phase[1:0]});
      for (int i = 0; i < 160; i++) begin
        if ($urandom_range(0, 1) == 0)
          queue_sample(16'(16'd20000 + $urandom_range(0, 15000)), 24'($urandom));
        else
          queue_sample(16'($urandom), 24'($urandom));
      end
      if (phase == 1) begin
        repeat (20) @(posedge clk);
        hold_go = 1'b1;
      end
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/bpc_pkg.sv
hdl/bpc_div.sv
hdl/barometric_pressure_compensation_top.sv
hdl/bpc_checker.sv
bench/barometric_pressure_compensation_top_tb.sv
